>>> rtl/core/ntsrw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the window bound function of the node table
// replay window. Used by ntsrw_cache and node_table_seqno_replay_window.
package ntsrw_pkg;

	localparam int NODE_ENTRIES = 16;
	localparam int CACHE_DEPTH  = 4;
	localparam int SEQ_MAXIMUM  = 65535;

	localparam int ENTRY_W = $clog2(NODE_ENTRIES);
	localparam int SLOT_W  = $clog2(CACHE_DEPTH);
	localparam int SP_W    = $clog2(CACHE_DEPTH + 1);
	localparam int CADDR_W = ENTRY_W + SLOT_W;

	localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd1;
	localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;

	localparam logic REG_WINDOW_RANGE = 1'b0;
	localparam logic REG_MAX_AGE      = 1'b1;

	typedef struct packed {
		logic               rd_en;
		logic [CADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [CADDR_W-1:0] wr_addr;
		logic [15:0]        wr_data;
		logic               clr_en;
		logic [ENTRY_W-1:0] clr_entry;
	} cache_ctrl_t;

	// Returns true when seq lies outside the window around lat.
	function automatic logic outside_window(input logic [15:0] lat, input logic [14:0] r,
			input logic [15:0] seq);
		logic signed [17:0] lim;
		logic               roll;
		logic [15:0]        m16;
		logic [15:0]        r16;
		logic [15:0]        hi;
		logic [15:0]        lo;
		logic               res;
		m16  = 16'(SEQ_MAXIMUM);
		r16  = {1'b0, r};
		lim  = $signed(18'(SEQ_MAXIMUM)) - $signed({3'b000, r});
		roll = $signed({2'b00, lat}) > lim;
		if (roll) begin
			hi = r16 - (m16 - lat);
		end else begin
			hi = lat + r16;
		end
		if (lat < r16) begin
			lo = m16 - (r16 - lat);
		end else begin
			lo = lat - r16;
		end
		if (lo < hi) begin
			res = (seq < lo) || (seq > hi);
		end else begin
			res = (seq > hi) && (seq < lo);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/ntsrw_cache.sv
`timescale 1ns / 1ps
// Sequence number cache: a memory of cached numbers with per-slot valid flags.
// Depends on ntsrw_pkg for sizes and the control struct.
module ntsrw_cache (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ntsrw_pkg::cache_ctrl_t ctrl,
	output logic [15:0]           rd_data,
	output logic                  rd_valid
);

	localparam int SLOTS = ntsrw_pkg::NODE_ENTRIES * ntsrw_pkg::CACHE_DEPTH;

	logic [15:0]      mem_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [15:0]      rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem_q[ctrl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.rd_en) begin
				rd_valid_q <= valid_q[ctrl.rd_addr];
			end
			// A clear and a write never target the same cycle.
			if (ctrl.clr_en) begin
				for (int k = 0; k < ntsrw_pkg::CACHE_DEPTH; k++) begin
					valid_q[{ctrl.clr_entry, ntsrw_pkg::SLOT_W'(k)}] <= 1'b0;
				end
			end else if (ctrl.wr_en) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> rtl/core/node_table_seqno_replay_window.sv
`timescale 1ns / 1ps
// Node table with sequence number replay window: sequencer, node table and
// config registers. Depends on ntsrw_pkg and ntsrw_cache.
//
// Usage: drive node_ident, seq_number and now_ms and raise start while busy
// is low; the transaction is taken at that edge and busy rises. The block
// scans the node table one entry per cycle with a single compare unit,
// stopping at the first matching entry, then reads the four cache slots of
// the chosen entry one per cycle from the cache memory, decides and updates.
// A transaction goes through the scan, an entry take-over for a new node,
// an age check, the cache reads, a decision and a commit, then the done
// strobe. An expired cache goes from the age check straight to the commit.
// The result (verdict, entry_index) is valid for exactly one cycle while done
// is high; the receiver cannot stall it. busy falls together with done, so a
// new transaction may start in that same cycle.
// Configuration (window_range at 0x0, max_age_ms at 0x4) must be written
// through the APB port while busy is low; the block does not enforce this.
// After reset every entry is empty, all cache slots are invalid,
// window_range is 32 and max_age_ms is 60000.
module node_table_seqno_replay_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] node_ident,
	input  logic [15:0] seq_number,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [3:0]  entry_index
);

	localparam int EW = ntsrw_pkg::ENTRY_W;
	localparam int SW = ntsrw_pkg::SLOT_W;
	localparam int PW = ntsrw_pkg::SP_W;
	localparam int NE = ntsrw_pkg::NODE_ENTRIES;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_TAKE, ST_CHECK, ST_READ, ST_DECIDE, ST_COMMIT
	} state_t;

	state_t      state_q;
	logic [14:0] window_range_q;
	logic [31:0] max_age_q;

	logic [63:0] ident_q [NE];
	logic [PW-1:0] sp_q [NE];
	logic [31:0] seen_q [NE];

	logic [63:0] id_q;
	logic [15:0] seq_q;
	logic [31:0] now_q;
	logic [EW-1:0] idx_q;
	logic [EW-1:0] entry_q;
	logic        have_free_q;
	logic [EW-1:0] free_at_q;
	logic [EW-1:0] min_pick_q;
	logic [31:0] best_q;
	logic [SW-1:0] rd_k_q;
	logic [SW-1:0] rd_k_s1;
	logic        rd_pend_s1;
	logic [15:0] lat_q;
	logic        lat_valid_q;
	logic        dup_q;
	logic [1:0]  verdict_q;
	logic        done_q;
	logic [3:0]  index_q;

	logic [EW-1:0] tab_idx;
	logic [63:0]   tab_ident;
	logic [PW-1:0] tab_sp;
	logic [31:0]   tab_seen;
	logic          tab_empty;
	logic [PW-1:0] sp_inc;
	logic [PW-1:0] sp_next;
	logic [EW-1:0] take_idx;
	logic          cfg_wr;

	ntsrw_pkg::cache_ctrl_t cctrl;
	logic [15:0] c_rd_data;
	logic        c_rd_valid;

	ntsrw_cache u_cache (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cctrl),
		.rd_data (c_rd_data),
		.rd_valid(c_rd_valid)
	);

	// One table read port, addressed by the scan counter or the chosen entry.
	assign tab_idx   = (state_q == ST_SCAN) ? idx_q : entry_q;
	assign tab_ident = ident_q[tab_idx];
	assign tab_sp    = sp_q[tab_idx];
	assign tab_seen  = seen_q[tab_idx];
	assign tab_empty = tab_sp >= PW'(ntsrw_pkg::CACHE_DEPTH);
	assign sp_inc    = tab_sp + PW'(1);
	assign sp_next   = (sp_inc >= PW'(ntsrw_pkg::CACHE_DEPTH)) ? '0 : sp_inc;
	assign take_idx  = have_free_q ? free_at_q : min_pick_q;

	always_comb begin
		cctrl           = '0;
		cctrl.rd_en     = (state_q == ST_READ);
		cctrl.rd_addr   = {entry_q, rd_k_q};
		cctrl.wr_addr   = {entry_q, SW'(sp_next)};
		cctrl.wr_data   = seq_q;
		cctrl.clr_entry = (state_q == ST_TAKE) ? take_idx : entry_q;
		cctrl.wr_en     = (state_q == ST_COMMIT) && (verdict_q == ntsrw_pkg::VERDICT_ACCEPT);
		cctrl.clr_en    = (state_q == ST_TAKE)
			|| ((state_q == ST_CHECK) && ((now_q - tab_seen) >= max_age_q));
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ntsrw_pkg::REG_MAX_AGE) ? max_age_q
		: {17'd0, window_range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_range_q <= 15'd32;
			max_age_q      <= 32'd60000;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ntsrw_pkg::REG_WINDOW_RANGE: window_range_q <= pwdata[14:0];
				ntsrw_pkg::REG_MAX_AGE:      max_age_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Identifiers need no reset: they are only compared on used entries.
	always_ff @(posedge clk) begin
		if (state_q == ST_TAKE) begin
			ident_q[take_idx] <= id_q;
		end
		if (start && !busy) begin
			id_q  <= node_ident;
			seq_q <= seq_number;
			now_q <= now_ms;
		end
		if (rd_pend_s1) begin
			if (rd_k_s1 == SW'(tab_sp)) begin
				lat_q <= c_rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < NE; i++) begin
				sp_q[i]   <= PW'(ntsrw_pkg::CACHE_DEPTH);
				seen_q[i] <= '0;
			end
			idx_q       <= '0;
			entry_q     <= '0;
			have_free_q <= 1'b0;
			free_at_q   <= '0;
			min_pick_q  <= '0;
			best_q      <= '0;
			rd_k_q      <= '0;
			rd_k_s1     <= '0;
			rd_pend_s1  <= 1'b0;
			lat_valid_q <= 1'b0;
			dup_q       <= 1'b0;
			verdict_q   <= ntsrw_pkg::VERDICT_ACCEPT;
			done_q      <= 1'b0;
			index_q     <= '0;
		end else begin
			done_q     <= 1'b0;
			rd_pend_s1 <= (state_q == ST_READ);
			rd_k_s1    <= rd_k_q;
			if (rd_pend_s1) begin
				if (rd_k_s1 == SW'(tab_sp)) begin
					lat_valid_q <= c_rd_valid;
				end
				if (c_rd_valid && (c_rd_data == seq_q)) begin
					dup_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						have_free_q <= 1'b0;
						best_q      <= '1;
						min_pick_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (tab_seen <= best_q) begin
						best_q     <= tab_seen;
						min_pick_q <= idx_q;
					end
					if (tab_empty) begin
						if (!have_free_q) begin
							have_free_q <= 1'b1;
							free_at_q   <= idx_q;
						end
					end else if (tab_ident == id_q) begin
						entry_q <= idx_q;
						state_q <= ST_CHECK;
					end
					if (!(!tab_empty && (tab_ident == id_q))) begin
						if (idx_q == EW'(NE - 1)) begin
							state_q <= ST_TAKE;
						end
						idx_q <= idx_q + EW'(1);
					end
				end
				ST_TAKE: begin
					entry_q          <= take_idx;
					sp_q[take_idx]   <= '0;
					seen_q[take_idx] <= '0;
					state_q          <= ST_CHECK;
				end
				ST_CHECK: begin
					verdict_q   <= ntsrw_pkg::VERDICT_ACCEPT;
					lat_valid_q <= 1'b0;
					dup_q       <= 1'b0;
					rd_k_q      <= '0;
					if ((now_q - tab_seen) >= max_age_q) begin
						state_q <= ST_COMMIT;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_k_q <= rd_k_q + SW'(1);
					if (rd_k_q == SW'(ntsrw_pkg::CACHE_DEPTH - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// Waits here until the last registered cache read has returned.
					if (!rd_pend_s1) begin
						if (!lat_valid_q) begin
							verdict_q <= ntsrw_pkg::VERDICT_ACCEPT;
						end else if (ntsrw_pkg::outside_window(lat_q, window_range_q, seq_q)) begin
							verdict_q <= ntsrw_pkg::VERDICT_OUTSIDE;
						end else if (dup_q) begin
							verdict_q <= ntsrw_pkg::VERDICT_DUPLICATE;
						end else begin
							verdict_q <= ntsrw_pkg::VERDICT_ACCEPT;
						end
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (verdict_q == ntsrw_pkg::VERDICT_ACCEPT) begin
						sp_q[entry_q]   <= sp_next;
						seen_q[entry_q] <= now_q;
					end
					index_q <= 4'(entry_q);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign verdict     = verdict_q;
	assign entry_index = index_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe lasted more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (verdict == ntsrw_pkg::VERDICT_ACCEPT || verdict == ntsrw_pkg::VERDICT_OUTSIDE
			|| verdict == ntsrw_pkg::VERDICT_DUPLICATE))
		else $error("result carries an undefined verdict");

	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |=> (done && !busy))
		else $error("commit did not deliver a result");

endmodule
